// ===== rtl/afw_pkg.sv =====
// Shared types, codes and sizes for the aspect-fit window calculator.
`timescale 1ns / 1ps

package afw_pkg;

    // Coordinate and datapath sizes
    localparam int COORD_BITS     = 13;
    localparam int MODE_BITS      = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUOT_BITS      = COORD_BITS + 2;   // quotients stay below 16/9 of 2^13
    localparam int PROD_BITS      = 2 * COORD_BITS;
    localparam int SWIN_BITS      = COORD_BITS + 3;   // signed window coordinates
    localparam int CMP_BITS       = COORD_BITS + 4;   // ratio cross products
    localparam int PLAN_BITS      = 3;

    // Draw modes
    localparam logic [MODE_BITS-1:0] MODE_STRETCH       = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_CROP_16_9     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_LETTERBOX     = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_CROP_4_3      = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_LETTERBOX_4_3 = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_MODE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_HEIGHT = 2'd2;

    // Reset values of the target size
    localparam logic [COORD_BITS-1:0] TARGET_WIDTH_RST  = 13'd1280;
    localparam logic [COORD_BITS-1:0] TARGET_HEIGHT_RST = 13'd720;

    // Ratio terms
    localparam logic [COORD_BITS-1:0] RATIO_WIDE_NUM = 13'd16;
    localparam logic [COORD_BITS-1:0] RATIO_WIDE_DEN = 13'd9;
    localparam logic [COORD_BITS-1:0] RATIO_STD_NUM  = 13'd4;
    localparam logic [COORD_BITS-1:0] RATIO_STD_DEN  = 13'd3;
    localparam logic [COORD_BITS-1:0] DIVISOR_ONE    = 13'd1;

    // What the placement stage does with the quotient
    localparam logic [PLAN_BITS-1:0] PLAN_NONE    = 3'd0;  // zero camera size
    localparam logic [PLAN_BITS-1:0] PLAN_STRETCH = 3'd1;
    localparam logic [PLAN_BITS-1:0] PLAN_SRC_H   = 3'd2;  // crop camera width
    localparam logic [PLAN_BITS-1:0] PLAN_SRC_V   = 3'd3;  // crop camera height
    localparam logic [PLAN_BITS-1:0] PLAN_DST_V   = 3'd4;  // bars above and below
    localparam logic [PLAN_BITS-1:0] PLAN_DST_H   = 3'd5;  // bars left and right

    typedef struct packed {
        logic [COORD_BITS-1:0] camera_width;
        logic [COORD_BITS-1:0] camera_height;
    } cam_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_left;
        logic [COORD_BITS-1:0] src_top;
        logic [COORD_BITS-1:0] src_right;
        logic [COORD_BITS-1:0] src_bottom;
        logic [COORD_BITS-1:0] dst_left;
        logic [COORD_BITS-1:0] dst_top;
        logic [COORD_BITS-1:0] dst_right;
        logic [COORD_BITS-1:0] dst_bottom;
        logic                  window_valid;
    } result_t;

    typedef struct packed {
        logic [PLAN_BITS-1:0]  plan;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } side_t;

    typedef struct packed {
        side_t                 side;
        logic [COORD_BITS-1:0] opa;
        logic [COORD_BITS-1:0] opb;
        logic [COORD_BITS-1:0] divisor;
    } op_t;

    typedef struct packed {
        side_t                 side;
        logic [COORD_BITS-1:0] rem;
        logic [QUOT_BITS-1:0]  work;     // dividend bits out at the top, quotient in below
        logic [COORD_BITS-1:0] divisor;
    } div_t;

    typedef struct packed {
        logic signed [SWIN_BITS-1:0] l;
        logic signed [SWIN_BITS-1:0] t;
        logic signed [SWIN_BITS-1:0] r;
        logic signed [SWIN_BITS-1:0] b;
    } swin_t;

    typedef struct packed {
        swin_t                 src;
        swin_t                 dst;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic                  valid;
    } place_t;

endpackage

// ===== rtl/afw_prep.sv =====
// Operand setup: ratio test, mode decode and dividend multiply, two stages.
`timescale 1ns / 1ps

module afw_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [afw_pkg::MODE_BITS-1:0]  draw_mode,
    input  logic [afw_pkg::COORD_BITS-1:0] target_width,
    input  logic [afw_pkg::COORD_BITS-1:0] target_height,
    input  logic                           take_valid,
    output logic                           take_ready,
    input  afw_pkg::cam_t                  take_data,
    output logic                           give_valid,
    input  logic                           give_ready,
    output afw_pkg::div_t                  give_data
);

    logic                                op_valid_reg;
    afw_pkg::op_t                        op_reg;
    afw_pkg::op_t                        op_next;
    logic                                div_valid_reg;
    afw_pkg::div_t                       div_reg;
    afw_pkg::div_t                       div_next;
    logic                                op_ready;
    logic [afw_pkg::COORD_BITS-1:0]      w;
    logic [afw_pkg::COORD_BITS-1:0]      h;
    logic [afw_pkg::CMP_BITS-1:0]        w_ext;
    logic [afw_pkg::CMP_BITS-1:0]        h_ext;
    logic                                wide_16_9;
    logic                                wide_4_3;
    logic [afw_pkg::PROD_BITS-1:0]       prod;

    assign w = take_data.camera_width;
    assign h = take_data.camera_height;
    assign w_ext = {{(afw_pkg::CMP_BITS-afw_pkg::COORD_BITS){1'b0}}, w};
    assign h_ext = {{(afw_pkg::CMP_BITS-afw_pkg::COORD_BITS){1'b0}}, h};

    // Compare the frame ratio against 16:9 and 4:3 by cross products
    assign wide_16_9 = ((w_ext << 3) + w_ext) > (h_ext << 4);
    assign wide_4_3  = ((w_ext << 1) + w_ext) > (h_ext << 2);

    // Pick the division that the mode and ratio call for
    always_comb
    begin
        op_next.side.w    = w;
        op_next.side.h    = h;
        op_next.side.plan = afw_pkg::PLAN_STRETCH;
        op_next.opa       = '0;
        op_next.opb       = '0;
        op_next.divisor   = afw_pkg::DIVISOR_ONE;
        unique case (draw_mode)
            afw_pkg::MODE_CROP_16_9:
            begin
                if (wide_16_9)
                begin
                    op_next.side.plan = afw_pkg::PLAN_SRC_H;
                    op_next.opa       = h;
                    op_next.opb       = afw_pkg::RATIO_WIDE_NUM;
                    op_next.divisor   = afw_pkg::RATIO_WIDE_DEN;
                end
                else
                begin
                    op_next.side.plan = afw_pkg::PLAN_SRC_V;
                    op_next.opa       = w;
                    op_next.opb       = afw_pkg::RATIO_WIDE_DEN;
                    op_next.divisor   = afw_pkg::RATIO_WIDE_NUM;
                end
            end
            afw_pkg::MODE_LETTERBOX:
            begin
                if (wide_16_9)
                begin
                    op_next.side.plan = afw_pkg::PLAN_DST_V;
                    op_next.opa       = target_width;
                    op_next.opb       = h;
                    op_next.divisor   = w;
                end
                else
                begin
                    op_next.side.plan = afw_pkg::PLAN_DST_H;
                    op_next.opa       = target_height;
                    op_next.opb       = w;
                    op_next.divisor   = h;
                end
            end
            afw_pkg::MODE_CROP_4_3:
            begin
                if (wide_4_3)
                begin
                    op_next.side.plan = afw_pkg::PLAN_SRC_H;
                    op_next.opa       = h;
                    op_next.opb       = afw_pkg::RATIO_STD_NUM;
                    op_next.divisor   = afw_pkg::RATIO_STD_DEN;
                end
                else
                begin
                    op_next.side.plan = afw_pkg::PLAN_SRC_V;
                    op_next.opa       = w;
                    op_next.opb       = afw_pkg::RATIO_STD_DEN;
                    op_next.divisor   = afw_pkg::RATIO_STD_NUM;
                end
            end
            afw_pkg::MODE_LETTERBOX_4_3:
            begin
                if (wide_4_3)
                begin
                    op_next.side.plan = afw_pkg::PLAN_DST_V;
                    op_next.opa       = target_height;
                    op_next.opb       = afw_pkg::RATIO_STD_DEN;
                    op_next.divisor   = afw_pkg::RATIO_STD_NUM;
                end
                else
                begin
                    op_next.side.plan = afw_pkg::PLAN_DST_H;
                    op_next.opa       = target_width;
                    op_next.opb       = afw_pkg::RATIO_STD_NUM;
                    op_next.divisor   = afw_pkg::RATIO_STD_DEN;
                end
            end
            default:
            begin
                op_next.side.plan = afw_pkg::PLAN_STRETCH;
            end
        endcase
        // Zero camera size: nothing to divide
        if (w == '0 || h == '0)
        begin
            op_next.side.plan = afw_pkg::PLAN_NONE;
            op_next.opa       = '0;
            op_next.opb       = '0;
            op_next.divisor   = afw_pkg::DIVISOR_ONE;
        end
    end

    // Form the dividend and split it into the first remainder and the shift word
    assign prod = {{afw_pkg::COORD_BITS{1'b0}}, op_reg.opa}
                * {{afw_pkg::COORD_BITS{1'b0}}, op_reg.opb};

    always_comb
    begin
        div_next.side    = op_reg.side;
        div_next.divisor = op_reg.divisor;
        div_next.rem     = {{(afw_pkg::COORD_BITS-(afw_pkg::PROD_BITS-afw_pkg::QUOT_BITS)){1'b0}},
                            prod[afw_pkg::PROD_BITS-1:afw_pkg::QUOT_BITS]};
        div_next.work    = prod[afw_pkg::QUOT_BITS-1:0];
    end

    // Handshake between the two stages
    assign op_ready   = !div_valid_reg || give_ready;
    assign take_ready = !op_valid_reg || op_ready;
    assign give_valid = div_valid_reg;
    assign give_data  = div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_ready)
            begin
                op_valid_reg <= take_valid;
            end
            if (op_ready)
            begin
                div_valid_reg <= op_valid_reg;
            end
        end
    end

    // Load payload on each transaction
    always_ff @(posedge clk)
    begin
        if (take_ready && take_valid)
        begin
            op_reg <= op_next;
        end
        if (op_ready && op_valid_reg)
        begin
            div_reg <= div_next;
        end
    end

endmodule

// ===== rtl/afw_div_cell.sv =====
// One restoring divider cell: produces one quotient bit per pass.
`timescale 1ns / 1ps

module afw_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take_valid,
    output logic          take_ready,
    input  afw_pkg::div_t take_data,
    output logic          give_valid,
    input  logic          give_ready,
    output afw_pkg::div_t give_data
);

    logic                              valid_reg;
    afw_pkg::div_t                     data_reg;
    afw_pkg::div_t                     data_next;
    logic [afw_pkg::COORD_BITS:0]      acc;
    logic [afw_pkg::COORD_BITS:0]      diff;
    logic                              fits;

    // Shift in the next dividend bit and try the subtract
    assign acc  = {take_data.rem, take_data.work[afw_pkg::QUOT_BITS-1]};
    assign diff = acc - {1'b0, take_data.divisor};
    assign fits = acc >= {1'b0, take_data.divisor};

    always_comb
    begin
        data_next.side    = take_data.side;
        data_next.divisor = take_data.divisor;
        data_next.rem     = fits ? diff[afw_pkg::COORD_BITS-1:0]
                                 : acc[afw_pkg::COORD_BITS-1:0];
        data_next.work    = {take_data.work[afw_pkg::QUOT_BITS-2:0], fits};
    end

    assign take_ready = !valid_reg || give_ready;
    assign give_valid = valid_reg;
    assign give_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_ready)
        begin
            valid_reg <= take_valid;
        end
    end

    // Advance payload with the transaction
    always_ff @(posedge clk)
    begin
        if (take_ready && take_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/afw_place.sv =====
// Window placement: centers the divided size into the source or destination window, or keeps full frames for stretch.
`timescale 1ns / 1ps

module afw_place (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [afw_pkg::COORD_BITS-1:0] target_width,
    input  logic [afw_pkg::COORD_BITS-1:0] target_height,
    input  logic                           take_valid,
    output logic                           take_ready,
    input  afw_pkg::div_t                  take_data,
    output logic                           give_valid,
    input  logic                           give_ready,
    output afw_pkg::place_t                give_data
);

    logic                               valid_reg;
    afw_pkg::place_t                    data_reg;
    afw_pkg::place_t                    data_next;
    logic signed [afw_pkg::SWIN_BITS-1:0] ws;
    logic signed [afw_pkg::SWIN_BITS-1:0] hs;
    logic signed [afw_pkg::SWIN_BITS-1:0] tws;
    logic signed [afw_pkg::SWIN_BITS-1:0] ths;
    logic signed [afw_pkg::SWIN_BITS-1:0] qs;
    logic signed [afw_pkg::SWIN_BITS-1:0] span;
    logic signed [afw_pkg::SWIN_BITS-1:0] gap;
    logic signed [afw_pkg::SWIN_BITS-1:0] off;

    // Widen everything to signed window coordinates
    assign ws  = $signed({{(afw_pkg::SWIN_BITS-afw_pkg::COORD_BITS){1'b0}}, take_data.side.w});
    assign hs  = $signed({{(afw_pkg::SWIN_BITS-afw_pkg::COORD_BITS){1'b0}}, take_data.side.h});
    assign tws = $signed({{(afw_pkg::SWIN_BITS-afw_pkg::COORD_BITS){1'b0}}, target_width});
    assign ths = $signed({{(afw_pkg::SWIN_BITS-afw_pkg::COORD_BITS){1'b0}}, target_height});
    assign qs  = $signed({{(afw_pkg::SWIN_BITS-afw_pkg::QUOT_BITS){1'b0}}, take_data.work});

    // Pick the span the quotient is centered in
    always_comb
    begin
        case (take_data.side.plan)
            afw_pkg::PLAN_SRC_H: span = ws;
            afw_pkg::PLAN_SRC_V: span = hs;
            afw_pkg::PLAN_DST_V: span = ths;
            afw_pkg::PLAN_DST_H: span = tws;
            default:             span = qs;
        endcase
    end

    // Halve the leftover space, truncating toward zero
    assign gap = span - qs;
    assign off = $signed(gap + {{(afw_pkg::SWIN_BITS-1){1'b0}},
                                gap[afw_pkg::SWIN_BITS-1]}) >>> 1;

    always_comb
    begin
        data_next.w     = take_data.side.w;
        data_next.h     = take_data.side.h;
        data_next.valid = 1'b1;
        data_next.src   = '{l: '0, t: '0, r: ws, b: hs};
        data_next.dst   = '{l: '0, t: '0, r: tws, b: ths};
        case (take_data.side.plan)
            afw_pkg::PLAN_NONE:
            begin
                data_next.valid = 1'b0;
                data_next.src   = '0;
                data_next.dst   = '0;
            end
            afw_pkg::PLAN_SRC_H: data_next.src = '{l: off, t: '0, r: off + qs, b: hs};
            afw_pkg::PLAN_SRC_V: data_next.src = '{l: '0, t: off, r: ws, b: off + qs};
            afw_pkg::PLAN_DST_V: data_next.dst = '{l: '0, t: off, r: tws, b: off + qs};
            afw_pkg::PLAN_DST_H: data_next.dst = '{l: off, t: '0, r: off + qs, b: ths};
            default:
            begin
                data_next.valid = 1'b1;
            end
        endcase
    end

    assign take_ready = !valid_reg || give_ready;
    assign give_valid = valid_reg;
    assign give_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_ready)
        begin
            valid_reg <= take_valid;
        end
    end

    // Hold the placed windows until the clip stage takes them
    always_ff @(posedge clk)
    begin
        if (take_ready && take_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/afw_clip.sv =====
// Clip stage and output register: intersects both windows with their frames.
`timescale 1ns / 1ps

module afw_clip (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [afw_pkg::COORD_BITS-1:0] target_width,
    input  logic [afw_pkg::COORD_BITS-1:0] target_height,
    input  logic                           take_valid,
    output logic                           take_ready,
    input  afw_pkg::place_t                take_data,
    output logic                           give_valid,
    input  logic                           give_ready,
    output afw_pkg::result_t               give_data
);

    logic              valid_reg;
    afw_pkg::result_t  data_reg;
    afw_pkg::result_t  data_next;
    afw_pkg::swin_t    src_clip;
    afw_pkg::swin_t    dst_clip;

    // Intersect a window with a frame at the origin; no overlap gives zeros
    function automatic afw_pkg::swin_t clip_win(
        input afw_pkg::swin_t                 win,
        input logic [afw_pkg::COORD_BITS-1:0] fw,
        input logic [afw_pkg::COORD_BITS-1:0] fh
    );
        afw_pkg::swin_t                     c;
        logic signed [afw_pkg::SWIN_BITS-1:0] fws;
        logic signed [afw_pkg::SWIN_BITS-1:0] fhs;
        fws = $signed({{(afw_pkg::SWIN_BITS-afw_pkg::COORD_BITS){1'b0}}, fw});
        fhs = $signed({{(afw_pkg::SWIN_BITS-afw_pkg::COORD_BITS){1'b0}}, fh});
        c.l = (win.l < 0) ? '0 : win.l;
        c.t = (win.t < 0) ? '0 : win.t;
        c.r = (win.r > fws) ? fws : win.r;
        c.b = (win.b > fhs) ? fhs : win.b;
        if (c.l >= c.r || c.t >= c.b)
        begin
            c = '0;
        end
        return c;
    endfunction

    assign src_clip = clip_win(take_data.src, take_data.w, take_data.h);
    assign dst_clip = clip_win(take_data.dst, target_width, target_height);

    // Clipped values lie inside the frame, so the low bits carry them
    always_comb
    begin
        data_next.src_left     = src_clip.l[afw_pkg::COORD_BITS-1:0];
        data_next.src_top      = src_clip.t[afw_pkg::COORD_BITS-1:0];
        data_next.src_right    = src_clip.r[afw_pkg::COORD_BITS-1:0];
        data_next.src_bottom   = src_clip.b[afw_pkg::COORD_BITS-1:0];
        data_next.dst_left     = dst_clip.l[afw_pkg::COORD_BITS-1:0];
        data_next.dst_top      = dst_clip.t[afw_pkg::COORD_BITS-1:0];
        data_next.dst_right    = dst_clip.r[afw_pkg::COORD_BITS-1:0];
        data_next.dst_bottom   = dst_clip.b[afw_pkg::COORD_BITS-1:0];
        data_next.window_valid = take_data.valid;
    end

    assign take_ready = !valid_reg || give_ready;
    assign give_valid = valid_reg;
    assign give_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_ready)
        begin
            valid_reg <= take_valid;
        end
    end

    // Hold the result until the sink takes the transaction
    always_ff @(posedge clk)
    begin
        if (take_ready && take_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/aspect_fit_window_calc.sv =====
// Path from an accepted transaction to its result: 2 setup, 15 divider, 2 out (place, clip) stages.
// Throughput: one transaction per cycle while win_stall is low; the 15-cell divider chain is fully pipelined.
// The divider chain yields one quotient bit per cell.
// Stalls fill bubbles first; input stall rises only when every stage holds data.
// Reset empties the pipeline and loads draw_mode 0, target 1280 x 720.
`timescale 1ns / 1ps

module aspect_fit_window_calc (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [afw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [afw_pkg::COORD_BITS-1:0]     cfg_data,
    input  logic                               cam_valid,
    output logic                               cam_stall,
    input  afw_pkg::cam_t                      cam_data,
    output logic                               win_valid,
    input  logic                               win_stall,
    output afw_pkg::result_t                   win_data
);

    logic [afw_pkg::MODE_BITS-1:0]  draw_mode_reg;
    logic [afw_pkg::COORD_BITS-1:0] target_width_reg;
    logic [afw_pkg::COORD_BITS-1:0] target_height_reg;
    logic                           prep_ready;
    logic                           chain_valid [0:afw_pkg::QUOT_BITS];
    logic                           chain_ready [0:afw_pkg::QUOT_BITS];
    afw_pkg::div_t                  chain_data  [0:afw_pkg::QUOT_BITS];
    logic                           place_valid;
    logic                           place_ready;
    afw_pkg::place_t                place_data;
    logic                           clip_ready;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_mode_reg     <= afw_pkg::MODE_STRETCH;
            target_width_reg  <= afw_pkg::TARGET_WIDTH_RST;
            target_height_reg <= afw_pkg::TARGET_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                afw_pkg::REG_DRAW_MODE:     draw_mode_reg     <= cfg_data[afw_pkg::MODE_BITS-1:0];
                afw_pkg::REG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                afw_pkg::REG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                default:
                begin
                    draw_mode_reg <= draw_mode_reg;
                end
            endcase
        end
    end

    // Setup stages feed the head of the divider chain
    assign cam_stall = !prep_ready;

    afw_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .draw_mode     (draw_mode_reg),
        .target_width  (target_width_reg),
        .target_height (target_height_reg),
        .take_valid    (cam_valid),
        .take_ready    (prep_ready),
        .take_data     (cam_data),
        .give_valid    (chain_valid[0]),
        .give_ready    (chain_ready[0]),
        .give_data     (chain_data[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < afw_pkg::QUOT_BITS; i++)
    begin : g_cell
        afw_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .take_valid (chain_valid[i]),
            .take_ready (chain_ready[i]),
            .take_data  (chain_data[i]),
            .give_valid (chain_valid[i+1]),
            .give_ready (chain_ready[i+1]),
            .give_data  (chain_data[i+1])
        );
    end

    assign chain_ready[afw_pkg::QUOT_BITS] = place_ready;

    afw_place u_place (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_width  (target_width_reg),
        .target_height (target_height_reg),
        .take_valid    (chain_valid[afw_pkg::QUOT_BITS]),
        .take_ready    (place_ready),
        .take_data     (chain_data[afw_pkg::QUOT_BITS]),
        .give_valid    (place_valid),
        .give_ready    (clip_ready),
        .give_data     (place_data)
    );

    afw_clip u_clip (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_width  (target_width_reg),
        .target_height (target_height_reg),
        .take_valid    (place_valid),
        .take_ready    (clip_ready),
        .take_data     (place_data),
        .give_valid    (win_valid),
        .give_ready    (!win_stall),
        .give_data     (win_data)
    );

endmodule
